// ===== sv/frame_deadline_pacer_assert.svh =====
// Assertion macros shared by the frame deadline pacer RTL.
// Clocked, reset-qualified implications; compiled out under SYNTHESIS.
`ifndef FRAME_DEADLINE_PACER_ASSERT_SVH
`define FRAME_DEADLINE_PACER_ASSERT_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked at every rising edge out of reset.
`define FDP_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication.
`define FDP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define FDP_ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define FDP_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ===== sv/fdp_pkg.sv =====
// Package for the frame deadline pacer: widths, codes, structs and
// the one-bit serial arithmetic helpers. No dependencies.
package fdp_pkg;

  localparam int unsigned TickW  = 64;  // tick counter and deadline width
  localparam int unsigned CfgW   = 32;  // period, tick rate and hint width
  localparam int unsigned MsW    = 10;  // bits needed for the ms scale
  localparam int unsigned NumW   = CfgW + MsW;  // remaining * 1000
  localparam int unsigned WinW   = CfgW + 5;    // period * 30 fits here
  localparam int unsigned ScanCntW = $clog2(TickW);
  localparam int unsigned DivCntW  = $clog2(NumW);
  localparam int unsigned AddrW  = 4;

  localparam logic [MsW-1:0]  MsPerSecond   = MsW'(1000);
  localparam logic [WinW-1:0] WindowRecover = WinW'(12);
  localparam logic [WinW-1:0] WindowStable  = WinW'(30);

  typedef enum logic [1:0] {
    ACT_ANCHOR   = 2'd0,
    ACT_WAIT     = 2'd1,
    ACT_LATE     = 2'd2,
    ACT_REANCHOR = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_SCAN = 2'd1,
    ST_DIV  = 2'd2,
    ST_LOAD = 2'd3
  } state_t;

  typedef enum logic [1:0] {
    REG_PERIOD  = 2'd0,
    REG_RATE    = 2'd1,
    REG_RECOVER = 2'd2
  } reg_idx_t;

  typedef struct packed {
    logic [CfgW-1:0] period_ticks;
    logic [CfgW-1:0] tick_rate;
    logic            short_window;
  } cfg_t;

  typedef struct packed {
    logic             d_zero;
    logic             now_ge_d;
    logic             past_window;
    logic             rem_gt_p;
    logic [CfgW-1:0]  rem;
    logic [TickW-1:0] now_plus_p;
    logic [TickW-1:0] d_plus_p;
  } scan_t;

  function automatic logic sub_borrow(input logic a, input logic b, input logic bin);
    sub_borrow = (~a & b) | (~(a ^ b) & bin);
  endfunction

  function automatic logic add_carry(input logic a, input logic b, input logic cin);
    add_carry = (a & b) | (cin & (a ^ b));
  endfunction

endpackage

// ===== sv/fdp_if.sv =====
// Valid/ready channel interfaces for the frame deadline pacer.
// Depends on fdp_pkg for field widths.
interface fdp_in_if;
  logic                     valid;
  logic                     ready;
  logic [fdp_pkg::TickW-1:0] now_ticks;

  modport source (output valid, output now_ticks, input ready);
  modport sink (input valid, input now_ticks, output ready);
endinterface

interface fdp_out_if;
  logic                     valid;
  logic                     ready;
  logic [1:0]               action;
  logic [fdp_pkg::CfgW-1:0]  sleep_hint_ms;
  logic [fdp_pkg::TickW-1:0] wait_until;
  logic [fdp_pkg::TickW-1:0] new_deadline;

  modport source (output valid, output action, output sleep_hint_ms,
                  output wait_until, output new_deadline, input ready);
  modport sink (input valid, input action, input sleep_hint_ms,
                input wait_until, input new_deadline, output ready);
endinterface

// ===== sv/frame_deadline_pacer.sv =====
// Frame deadline pacer top level: control sequencer, deadline register and
// output register. Depends on fdp_pkg, fdp_if, fdp_cfg, fdp_scan and fdp_div.
//
//   channel   dir   handshake            payload
//   in_ch     in    valid / ready        now_ticks
//   out_ch    out   valid / ready        action, sleep_hint_ms, wait_until,
//                                        new_deadline
//   config    in    psel/penable/pready  paddr, pwdata, prdata
//
// An item passes from acceptance through the 64-bit serial scan and, when a sleep
// hint is divided, through the 42-step restoring divider before its result is
// loaded into the output register.
// Synchronous active-low reset clears the deadline (unanchored) and control.
// A new item is taken while the previous result waits in the output register;
// a stalled output holds the finished result until the slot frees.
`include "frame_deadline_pacer_assert.svh"

module frame_deadline_pacer (
  input  logic                       clk,
  input  logic                       rst_n,
  fdp_in_if.sink                     in_ch,
  fdp_out_if.source                  out_ch,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [fdp_pkg::AddrW-1:0]  paddr,
  input  logic [fdp_pkg::CfgW-1:0]   pwdata,
  output logic [fdp_pkg::CfgW-1:0]   prdata,
  output logic                       pready
);

  fdp_pkg::cfg_t     cfg;
  fdp_pkg::scan_t    scan;
  fdp_pkg::state_t   state_r;
  fdp_pkg::state_t   state_nxt;
  fdp_pkg::action_t  action;

  logic [fdp_pkg::TickW-1:0] deadline_r;
  logic                      out_valid_r;
  fdp_pkg::action_t          out_action_r;
  logic [fdp_pkg::CfgW-1:0]  out_hint_r;
  logic [fdp_pkg::TickW-1:0] out_until_r;
  logic [fdp_pkg::TickW-1:0] out_deadline_r;

  logic                      in_fire;
  logic                      scan_start;
  logic                      scan_done;
  logic                      div_start;
  logic                      div_done;
  logic                      need_div;
  logic                      load;
  logic [fdp_pkg::CfgW-1:0]  remaining;
  logic [fdp_pkg::CfgW-1:0]  div_hint;
  logic [fdp_pkg::TickW-1:0] deadline_nxt;

  fdp_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  fdp_scan u_scan (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (scan_start),
    .now_ticks (in_ch.now_ticks),
    .deadline  (deadline_r),
    .cfg       (cfg),
    .done      (scan_done),
    .res       (scan)
  );

  assign remaining = scan.rem_gt_p ? cfg.period_ticks : scan.rem;

  fdp_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .remaining (remaining),
    .divisor   (cfg.tick_rate),
    .done      (div_done),
    .hint      (div_hint)
  );

  // Decision from the scan flags; held stable until the next scan starts.
  always_comb begin
    if (scan.d_zero) begin
      action = fdp_pkg::ACT_ANCHOR;
    end else if (scan.now_ge_d && scan.past_window) begin
      action = fdp_pkg::ACT_REANCHOR;
    end else if (scan.now_ge_d) begin
      action = fdp_pkg::ACT_LATE;
    end else begin
      action = fdp_pkg::ACT_WAIT;
    end
  end

  assign deadline_nxt = (action == fdp_pkg::ACT_ANCHOR ||
                         action == fdp_pkg::ACT_REANCHOR) ?
                        scan.now_plus_p : scan.d_plus_p;
  assign need_div = (action == fdp_pkg::ACT_WAIT) && (cfg.tick_rate != '0);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      fdp_pkg::ST_IDLE: if (in_ch.valid) state_nxt = fdp_pkg::ST_SCAN;
      fdp_pkg::ST_SCAN: begin
        if (scan_done) state_nxt = need_div ? fdp_pkg::ST_DIV : fdp_pkg::ST_LOAD;
      end
      fdp_pkg::ST_DIV:  if (div_done) state_nxt = fdp_pkg::ST_LOAD;
      fdp_pkg::ST_LOAD: if (!out_valid_r || out_ch.ready) state_nxt = fdp_pkg::ST_IDLE;
      default:          state_nxt = fdp_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ch.ready = 1'b0;
    scan_start  = 1'b0;
    div_start   = 1'b0;
    load        = 1'b0;
    case (state_r)
      fdp_pkg::ST_IDLE: begin
        in_ch.ready = 1'b1;
        scan_start  = in_ch.valid;
      end
      fdp_pkg::ST_SCAN: div_start = scan_done && need_div;
      fdp_pkg::ST_DIV:  div_start = 1'b0;
      fdp_pkg::ST_LOAD: load = !out_valid_r || out_ch.ready;
      default:          load = 1'b0;
    endcase
  end

  assign in_fire = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= fdp_pkg::ST_IDLE;
      deadline_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (load) begin
        deadline_r  <= deadline_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_action_r   <= action;
      out_hint_r     <= need_div ? div_hint : '0;
      out_until_r    <= (action == fdp_pkg::ACT_WAIT) ? deadline_r : '0;
      out_deadline_r <= deadline_nxt;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.action        = out_action_r;
  assign out_ch.sleep_hint_ms = out_hint_r;
  assign out_ch.wait_until    = out_until_r;
  assign out_ch.new_deadline  = out_deadline_r;

  `FDP_ASSERT_IMPLIES(a_accept_starts_scan, clk, rst_n, in_fire, scan_start)
  `FDP_ASSERT_IMPLIES(a_div_done_in_div, clk, rst_n, div_done, state_r == fdp_pkg::ST_DIV)
  `FDP_ASSERT_NEXT(a_load_tracks_deadline, clk, rst_n, load, out_ch.valid && deadline_r == out_ch.new_deadline)
  `FDP_ASSERT_IMPLIES(a_idle_fields_zero, clk, rst_n, out_ch.valid && out_ch.action != fdp_pkg::ACT_WAIT, out_ch.wait_until == '0 && out_ch.sleep_hint_ms == '0)

endmodule

// ===== sv/fdp_cfg.sv =====
// APB-style configuration registers of the frame deadline pacer.
// Depends on fdp_pkg for the register map and the cfg_t struct.
module fdp_cfg (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [fdp_pkg::AddrW-1:0]  paddr,
  input  logic [fdp_pkg::CfgW-1:0]   pwdata,
  output logic [fdp_pkg::CfgW-1:0]   prdata,
  output logic                       pready,
  output fdp_pkg::cfg_t              cfg
);

  fdp_pkg::cfg_t    cfg_r;
  fdp_pkg::cfg_t    cfg_nxt;
  fdp_pkg::reg_idx_t idx;
  logic             wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = fdp_pkg::reg_idx_t'(paddr[3:2]);

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (idx)
        fdp_pkg::REG_PERIOD:  cfg_nxt.period_ticks = pwdata;
        fdp_pkg::REG_RATE:    cfg_nxt.tick_rate    = pwdata;
        fdp_pkg::REG_RECOVER: cfg_nxt.short_window = pwdata[0];
        default:              cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    case (idx)
      fdp_pkg::REG_PERIOD:  prdata = cfg_r.period_ticks;
      fdp_pkg::REG_RATE:    prdata = cfg_r.tick_rate;
      fdp_pkg::REG_RECOVER: prdata = {{(fdp_pkg::CfgW-1){1'b0}}, cfg_r.short_window};
      default:              prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.period_ticks <= '0;
      cfg_r.tick_rate    <= '0;
      cfg_r.short_window <= 1'b1;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// ===== sv/fdp_scan.sv =====
// Bit-serial scan of now and the stored deadline, LSB first, one bit a cycle.
// Produces the compare flags, the low half of the remaining time, its cap flag and both sums.
// Depends on fdp_pkg.
module fdp_scan (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [fdp_pkg::TickW-1:0]  now_ticks,
  input  logic [fdp_pkg::TickW-1:0]  deadline,
  input  fdp_pkg::cfg_t              cfg,
  output logic                       done,
  output fdp_pkg::scan_t             res
);

  logic                          running_r;
  logic                          done_r;
  logic [fdp_pkg::ScanCntW-1:0]  cnt_r;
  logic [fdp_pkg::TickW-1:0]     now_sr_r;
  logic [fdp_pkg::TickW-1:0]     dl_sr_r;
  logic [fdp_pkg::CfgW-1:0]      per_sr_r;
  logic [fdp_pkg::WinW-1:0]      win_sr_r;
  logic [fdp_pkg::CfgW-1:0]      rem_sr_r;
  logic                          b_diff_r;   // now - D
  logic                          b_win_r;    // (now - D) - window
  logic                          b_rem_r;    // D - now
  logic                          b_cap_r;    // P - (D - now)
  logic                          c_now_r;    // now + P
  logic                          c_dl_r;     // D + P
  logic                          dnz_r;      // some bit of D was set

  logic                          n_bit;
  logic                          d_bit;
  logic                          p_bit;
  logic                          diff_bit;
  logic                          rem_bit;
  logic [fdp_pkg::WinW-1:0]      per_ext;
  logic [fdp_pkg::WinW-1:0]      win_load;

  assign n_bit    = now_sr_r[0];
  assign d_bit    = dl_sr_r[0];
  assign p_bit    = per_sr_r[0];
  assign diff_bit = n_bit ^ d_bit ^ b_diff_r;
  assign rem_bit  = d_bit ^ n_bit ^ b_rem_r;

  // Each product has a constant factor, so it reduces to a few shifted adds.
  assign per_ext  = {{(fdp_pkg::WinW-fdp_pkg::CfgW){1'b0}}, cfg.period_ticks};
  assign win_load = cfg.short_window ? per_ext * fdp_pkg::WindowRecover :
                                       per_ext * fdp_pkg::WindowStable;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      running_r <= 1'b0;
      done_r    <= 1'b0;
      cnt_r     <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        running_r <= 1'b1;
        cnt_r     <= '0;
      end else if (running_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == fdp_pkg::ScanCntW'(fdp_pkg::TickW - 1)) begin
          running_r <= 1'b0;
          done_r    <= 1'b1;
        end
      end
    end
  end

  // The sums shift in at the top while the operands shift out at the bottom.
  always_ff @(posedge clk) begin
    if (start) begin
      now_sr_r <= now_ticks;
      dl_sr_r  <= deadline;
      per_sr_r <= cfg.period_ticks;
      win_sr_r <= win_load;
      b_diff_r <= 1'b0;
      b_win_r  <= 1'b0;
      b_rem_r  <= 1'b0;
      b_cap_r  <= 1'b0;
      c_now_r  <= 1'b0;
      c_dl_r   <= 1'b0;
      dnz_r    <= 1'b0;
    end else if (running_r) begin
      now_sr_r <= {n_bit ^ p_bit ^ c_now_r, now_sr_r[fdp_pkg::TickW-1:1]};
      dl_sr_r  <= {d_bit ^ p_bit ^ c_dl_r, dl_sr_r[fdp_pkg::TickW-1:1]};
      per_sr_r <= {1'b0, per_sr_r[fdp_pkg::CfgW-1:1]};
      win_sr_r <= {1'b0, win_sr_r[fdp_pkg::WinW-1:1]};
      b_diff_r <= fdp_pkg::sub_borrow(n_bit, d_bit, b_diff_r);
      b_win_r  <= fdp_pkg::sub_borrow(diff_bit, win_sr_r[0], b_win_r);
      b_rem_r  <= fdp_pkg::sub_borrow(d_bit, n_bit, b_rem_r);
      b_cap_r  <= fdp_pkg::sub_borrow(p_bit, rem_bit, b_cap_r);
      c_now_r  <= fdp_pkg::add_carry(n_bit, p_bit, c_now_r);
      c_dl_r   <= fdp_pkg::add_carry(d_bit, p_bit, c_dl_r);
      dnz_r    <= dnz_r | d_bit;
    end
  end

  // Only the low half of the remaining time is kept; a larger value is capped.
  always_ff @(posedge clk) begin
    if (running_r && !cnt_r[fdp_pkg::ScanCntW-1]) begin
      rem_sr_r <= {rem_bit, rem_sr_r[fdp_pkg::CfgW-1:1]};
    end
  end

  assign done            = done_r;
  assign res.d_zero      = !dnz_r;
  assign res.now_ge_d    = !b_diff_r;
  assign res.past_window = !b_win_r;
  assign res.rem_gt_p    = b_cap_r;
  assign res.rem         = rem_sr_r;
  assign res.now_plus_p  = now_sr_r;
  assign res.d_plus_p    = dl_sr_r;

endmodule

// ===== sv/fdp_div.sv =====
// Restoring divider, one quotient bit a cycle, for the millisecond hint.
// Computes (remaining * 1000) / tick_rate and the adjusted, saturated hint.
// Depends on fdp_pkg.
module fdp_div (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [fdp_pkg::CfgW-1:0]  remaining,
  input  logic [fdp_pkg::CfgW-1:0]  divisor,
  output logic                      done,
  output logic [fdp_pkg::CfgW-1:0]  hint
);

  logic                          running_r;
  logic                          done_r;
  logic [fdp_pkg::DivCntW-1:0]   cnt_r;
  logic [fdp_pkg::NumW-1:0]      quo_r;
  logic [fdp_pkg::CfgW-1:0]      rem_r;
  logic [fdp_pkg::CfgW-1:0]      div_r;

  logic [fdp_pkg::NumW-1:0]      dividend;
  logic [fdp_pkg::CfgW:0]        shifted;
  logic [fdp_pkg::CfgW+1:0]      trial;
  logic [fdp_pkg::NumW-1:0]      quo_m1;

  assign dividend = {{fdp_pkg::MsW{1'b0}}, remaining} *
                    {{fdp_pkg::CfgW{1'b0}}, fdp_pkg::MsPerSecond};
  assign shifted  = {rem_r, quo_r[fdp_pkg::NumW-1]};
  assign trial    = {1'b0, shifted} - {2'b00, div_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      running_r <= 1'b0;
      done_r    <= 1'b0;
      cnt_r     <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        running_r <= 1'b1;
        cnt_r     <= '0;
      end else if (running_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == fdp_pkg::DivCntW'(fdp_pkg::NumW - 1)) begin
          running_r <= 1'b0;
          done_r    <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      div_r <= divisor;
    end else if (running_r) begin
      if (!trial[fdp_pkg::CfgW+1]) begin
        rem_r <= trial[fdp_pkg::CfgW-1:0];
        quo_r <= {quo_r[fdp_pkg::NumW-2:0], 1'b1};
      end else begin
        rem_r <= shifted[fdp_pkg::CfgW-1:0];
        quo_r <= {quo_r[fdp_pkg::NumW-2:0], 1'b0};
      end
    end
  end

  // Under two milliseconds the hint is zero; otherwise one less, saturated.
  assign quo_m1 = quo_r - 1'b1;

  always_comb begin
    if (quo_r < fdp_pkg::NumW'(2)) begin
      hint = '0;
    end else if (|quo_m1[fdp_pkg::NumW-1:fdp_pkg::CfgW]) begin
      hint = '1;
    end else begin
      hint = quo_m1[fdp_pkg::CfgW-1:0];
    end
  end

  assign done = done_r;

endmodule

// ===== tb/pacer_scoreboard_pkg.sv =====
`timescale 1ns / 100ps
// Scoreboard for the frame deadline pacer bench: a cycle-free model of the pacing decision,
// the register file it depends on, and the queue of results still to arrive. Uses fdp_pkg.
package pacer_scoreboard_pkg;
  import fdp_pkg::*;

  localparam logic [TickW-1:0] MsPerSec         = 64'd1000;
  localparam logic [TickW-1:0] ShortDebtPeriods = 64'd12;
  localparam logic [TickW-1:0] LongDebtPeriods  = 64'd30;
  localparam int unsigned      MaxReported      = 40;

  typedef struct packed {
    action_t          action;
    logic [CfgW-1:0]  sleep_hint_ms;
    logic [TickW-1:0] wait_until;
    logic [TickW-1:0] new_deadline;
  } pacing_t;

  class pacer_scoreboard;
    logic [CfgW-1:0]  period;
    logic [CfgW-1:0]  rate;
    logic             recover;
    logic [TickW-1:0] deadline;
    pacing_t          pacing_q[$];
    int unsigned      errors;
    int unsigned      results_seen;

    function new();
      period = '0;
      rate = '0;
      recover = 1'b1;
      deadline = '0;
      errors = 0;
      results_seen = 0;
    endfunction

    function logic [TickW-1:0] debt_window();
      return TickW'(period) * (recover ? ShortDebtPeriods : LongDebtPeriods);
    endfunction

    // The register index is taken from address bits 3:2, as the block decodes it.
    function void apply_write(logic [AddrW-1:0] addr, logic [CfgW-1:0] data);
      case (addr[AddrW-1:2])
        REG_PERIOD:  period = data;
        REG_RATE:    rate = data;
        REG_RECOVER: recover = data[0];
        default: ;
      endcase
    endfunction

    function logic [CfgW-1:0] register_value(reg_idx_t idx);
      case (idx)
        REG_PERIOD:  return period;
        REG_RATE:    return rate;
        REG_RECOVER: return CfgW'(recover);
        default:     return '0;
      endcase
    endfunction

    // Decides one frame and advances the stored deadline.
    function pacing_t pace_frame(logic [TickW-1:0] now);
      pacing_t          r;
      logic [TickW-1:0] p;
      logic [TickW-1:0] left;
      logic [TickW-1:0] ms;
      p = TickW'(period);
      r.sleep_hint_ms = '0;
      r.wait_until = '0;
      if (deadline == '0) begin
        r.action = ACT_ANCHOR;
        r.new_deadline = now + p;
      end else if (now >= deadline && now - deadline >= debt_window()) begin
        r.action = ACT_REANCHOR;
        r.new_deadline = now + p;
      end else if (now >= deadline) begin
        r.action = ACT_LATE;
        r.new_deadline = deadline + p;
      end else begin
        r.action = ACT_WAIT;
        r.wait_until = deadline;
        r.new_deadline = deadline + p;
        // The coarse sleep never covers more than one period of the time left.
        left = deadline - now;
        if (left > p) left = p;
        if (rate != '0) begin
          ms = left * MsPerSec / TickW'(rate);
          if (ms >= 64'd2) begin
            r.sleep_hint_ms = (ms - 64'd1 > TickW'(32'hFFFF_FFFF)) ? '1 : CfgW'(ms - 64'd1);
          end
        end
      end
      deadline = r.new_deadline;
      return r;
    endfunction

    function void note_frame(logic [TickW-1:0] now);
      pacing_q.push_back(pace_frame(now));
    endfunction

    function int unsigned pending();
      return pacing_q.size();
    endfunction

    task report(string what);
      if (errors < MaxReported) $display("mismatch: %s", what);
      errors++;
    endtask

    task check_result(logic [1:0] action, logic [CfgW-1:0] hint, logic [TickW-1:0] spin_to,
                      logic [TickW-1:0] next);
      pacing_t want;
      results_seen++;
      if (pacing_q.size() == 0) begin
        report($sformatf("result %0d arrived with no frame outstanding", results_seen));
        return;
      end
      want = pacing_q.pop_front();
      if (action !== want.action)
        report($sformatf("result %0d action %0d, expected %0d", results_seen, action,
                         want.action));
      if (hint !== want.sleep_hint_ms)
        report($sformatf("result %0d sleep_hint_ms %h, expected %h", results_seen, hint,
                         want.sleep_hint_ms));
      if (spin_to !== want.wait_until)
        report($sformatf("result %0d wait_until %h, expected %h", results_seen, spin_to,
                         want.wait_until));
      if (next !== want.new_deadline)
        report($sformatf("result %0d new_deadline %h, expected %h", results_seen, next,
                         want.new_deadline));
    endtask
  endclass

endpackage

// ===== tb/tb.sv =====
`timescale 1ns / 100ps
// Top-level bench for frame_deadline_pacer: drives frame events and register writes,
// checks every result against pacer_scoreboard_pkg. Needs fdp_pkg, fdp_if and the RTL.
module tb;
  import fdp_pkg::*;
  import pacer_scoreboard_pkg::*;

  localparam int unsigned CycleLimit     = 1_000_000;
  localparam int unsigned SinkHoldCycles = 400;
  localparam int unsigned DrainCycles    = 150;
  localparam int unsigned RandomPhases   = 7;
  localparam int unsigned FramesPerPhase = 97;
  localparam logic [AddrW-1:0] UnmappedAddr  = AddrW'(12);
  localparam logic [CfgW-1:0]  TypicalPeriod = 32'd16_666_667;
  localparam logic [CfgW-1:0]  TypicalRate   = 32'd1_000_000_000;

  logic             clk;
  logic             rst_n;
  logic             psel;
  logic             penable;
  logic             pwrite;
  logic [AddrW-1:0] paddr;
  logic [CfgW-1:0]  pwdata;
  logic [CfgW-1:0]  prdata;
  logic             pready;

  fdp_in_if  in_ch();
  fdp_out_if out_ch();

  pacer_scoreboard sb = new();

  bit          src_idling = 1'b1;
  bit          sink_idling = 1'b1;
  int unsigned src_burst = 0;
  int unsigned sink_hold = 0;
  int unsigned cycle_count = 0;

  frame_deadline_pacer dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("frame_deadline_pacer test failed");
      $finish;
    end
  end

  function automatic int unsigned draw_gap(bit idling);
    return idling ? $urandom_range(0, 13) : 0;
  endfunction

  function automatic logic [TickW-1:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [CfgW-1:0] recover_word(bit on);
    return ($urandom & ~32'd1) | CfgW'(on);
  endfunction

  function automatic logic [CfgW-1:0] pick_period();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return '1;
      2:       return $urandom_range(1, 1000);
      3, 4:    return $urandom_range(100_000, 50_000_000);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [CfgW-1:0] pick_rate();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return 32'd1;
      2:       return '1;
      3, 4:    return $urandom_range(1000, 1_000_000_000);
      default: return $urandom;
    endcase
  endfunction

  // Frame times are mostly placed around the current deadline so that every
  // action and both window edges come up often; the rest are arbitrary.
  function automatic logic [TickW-1:0] pick_now();
    logic [TickW-1:0] d;
    logic [TickW-1:0] p;
    logic [TickW-1:0] win;
    d = sb.deadline;
    p = TickW'(sb.period);
    win = sb.debt_window();
    if (d == '0 || $urandom_range(0, 99) < 12) begin
      case ($urandom_range(0, 7))
        0:       return '0;
        1:       return '1;
        default: return rand64();
      endcase
    end
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return d - 64'd1 - (rand64() % (2 * p + 64'd2));
      4, 5, 6:    return d + (rand64() % (win + 64'd1));
      7:          return d + win - TickW'($urandom_range(0, 1));
      default:    return d + win + (rand64() % (64'd1 << $urandom_range(1, 63)));
    endcase
  endfunction

  task automatic send_frame(input logic [TickW-1:0] now);
    int unsigned gap;
    gap = (src_burst > 0) ? 0 : draw_gap(src_idling);
    if (src_burst > 0) src_burst--;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.now_ticks <= now;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    sb.note_frame(now);
  endtask

  task automatic pause_until_drained();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  task automatic bus_write(input logic [AddrW-1:0] addr, input logic [CfgW-1:0] data);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    sb.apply_write(addr, data);
  endtask

  task automatic bus_check(input reg_idx_t idx);
    logic [CfgW-1:0] got;
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= AddrW'({idx, 2'b00});
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    got = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
    if (got !== sb.register_value(idx))
      sb.report($sformatf("register %s reads %h, expected %h", idx.name(), got,
                          sb.register_value(idx)));
  endtask

  task automatic set_register(input reg_idx_t idx, input logic [CfgW-1:0] data);
    bus_write(AddrW'({idx, 2'b00}), data);
    bus_check(idx);
  endtask

  initial begin : result_sink
    int unsigned stall;
    out_ch.ready <= 1'b0;
    do @(posedge clk); while (rst_n !== 1'b1);
    forever begin
      stall = draw_gap(sink_idling);
      if (sink_hold > 0) begin
        stall = sink_hold;
        sink_hold = 0;
      end
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (out_ch.valid !== 1'b1);
      sb.check_result(out_ch.action, out_ch.sleep_hint_ms, out_ch.wait_until,
                      out_ch.new_deadline);
    end
  end

  initial begin : frame_source
    logic [TickW-1:0] p;
    rst_n <= 1'b0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    in_ch.valid <= 1'b0;
    in_ch.now_ticks <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Reset values, then zero period: every frame that is not early anchors or re-anchors.
    bus_check(REG_PERIOD);
    bus_check(REG_RATE);
    bus_check(REG_RECOVER);
    send_frame('0);
    send_frame('0);
    send_frame('1);
    send_frame(64'd5);
    send_frame('1);

    // A write outside the register map must leave every register alone.
    pause_until_drained();
    bus_write(UnmappedAddr, $urandom);
    bus_check(REG_PERIOD);
    bus_check(REG_RATE);
    bus_check(REG_RECOVER);

    set_register(REG_PERIOD, TypicalPeriod);
    set_register(REG_RATE, TypicalRate);
    set_register(REG_RECOVER, recover_word(1'b1));
    p = TickW'(sb.period);
    send_frame(64'd1000);
    send_frame(sb.deadline - p);
    send_frame(sb.deadline - 64'd1);
    send_frame(sb.deadline);
    send_frame(sb.deadline + sb.debt_window() - 64'd1);
    send_frame(sb.deadline + sb.debt_window());

    pause_until_drained();
    set_register(REG_RECOVER, recover_word(1'b0));
    send_frame(sb.deadline + sb.debt_window() - 64'd1);
    send_frame(sb.deadline + sb.debt_window());
    send_frame(sb.deadline + 64'd12 * p);
    // Re-anchoring one period short of the wrap stores a zero deadline.
    send_frame(64'd0 - p);
    send_frame('1);
    send_frame('0);

    // Huge period against a one-tick-per-second counter saturates the hint.
    pause_until_drained();
    set_register(REG_PERIOD, '1);
    set_register(REG_RATE, 32'd1);
    p = TickW'(sb.period);
    send_frame(sb.deadline - 64'd1);
    send_frame(sb.deadline - p);

    // Hints around the two-millisecond threshold.
    pause_until_drained();
    set_register(REG_PERIOD, 32'd100);
    set_register(REG_RATE, 32'd1000);
    set_register(REG_RECOVER, recover_word(1'b1));
    send_frame(sb.deadline - 64'd1);
    send_frame(sb.deadline - 64'd2);
    send_frame(sb.deadline - 64'd3);
    pause_until_drained();
    set_register(REG_RATE, '1);
    send_frame(sb.deadline - 64'd100);

    for (int ph = 0; ph < RandomPhases; ph++) begin
      pause_until_drained();
      set_register(REG_PERIOD, pick_period());
      set_register(REG_RATE, pick_rate());
      set_register(REG_RECOVER, recover_word($urandom_range(0, 1)));
      src_idling = (ph % 3) != 2;
      sink_idling = (ph % 3) != 1;
      for (int n = 0; n < FramesPerPhase; n++) begin
        if (n == FramesPerPhase / 2) pause_until_drained();
        // Hold the result side off while frames keep coming, so the input backs up.
        if (ph == 2 && n == 20) begin
          sink_hold = SinkHoldCycles;
          src_burst = 24;
        end
        send_frame(pick_now());
      end
    end

    pause_until_drained();
    repeat (DrainCycles) @(posedge clk);
    if (sb.errors == 0) begin
      $display("frame_deadline_pacer test passed");
    end else begin
      $display("frame_deadline_pacer test failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+sv
sv/fdp_pkg.sv
sv/fdp_if.sv
sv/fdp_cfg.sv
sv/fdp_scan.sv
sv/fdp_div.sv
sv/frame_deadline_pacer.sv
tb/pacer_scoreboard_pkg.sv
tb/tb.sv
